// ===== hw/rtl/frbt_pkg.sv =====
`timescale 1ns / 1ps

package frbt_pkg;

    localparam int CMD_BITS      = 2;
    localparam int FRAME_ID_BITS = 29;
    localparam int LEN_BITS      = 4;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 29;

    // freeze_instant is reported on at most this many low bits
    localparam int INSTANT_OUT_BITS = 48;

    localparam logic [LEN_BITS-1:0]  MIN_FREEZE_LEN = LEN_BITS'(3);
    localparam logic [LEN_BITS-1:0]  MIN_REARM_LEN  = LEN_BITS'(1);
    localparam logic [BYTE_BITS-1:0] LAST_RESET     = 8'hFF;

    localparam logic [FRAME_ID_BITS-1:0] FREEZE_ID_RESET = FRAME_ID_BITS'(0);
    localparam logic [FRAME_ID_BITS-1:0] REARM_ID_RESET  = FRAME_ID_BITS'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_RX      = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_REARM   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SELF      = 2'd0,
        CFG_FREEZE_ID = 2'd1,
        CFG_REARM_ID  = 2'd2
    } t_cfg_idx;

endpackage

// ===== hw/rtl/frbt_in_if.sv =====
`timescale 1ns / 1ps

interface frbt_in_if
    import frbt_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                     valid;
    logic                     ready;
    logic [CMD_BITS-1:0]      cmd;
    logic [FRAME_ID_BITS-1:0] frame_id;
    logic [LEN_BITS-1:0]      frame_len;
    logic [BYTE_BITS-1:0]     rx_byte0;
    logic [BYTE_BITS-1:0]     rx_byte1;
    logic [BYTE_BITS-1:0]     rx_byte2;
    logic [BYTE_BITS-1:0]     trigger_cause;
    logic [TIME_BITS-1:0]     now_us;

    modport source (
        output valid, cmd, frame_id, frame_len, rx_byte0, rx_byte1, rx_byte2,
               trigger_cause, now_us,
        input  ready
    );

    modport sink (
        input  valid, cmd, frame_id, frame_len, rx_byte0, rx_byte1, rx_byte2,
               trigger_cause, now_us,
        output ready
    );
endinterface

// ===== hw/rtl/frbt_out_if.sv =====
`timescale 1ns / 1ps

interface frbt_out_if
    import frbt_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                     valid;
    logic                     ready;
    logic                     send_valid;
    logic [FRAME_ID_BITS-1:0] send_id;
    logic [BYTE_BITS-1:0]     send_byte0;
    logic [BYTE_BITS-1:0]     send_byte1;
    logic [BYTE_BITS-1:0]     send_byte2;
    logic                     freeze_event;
    logic                     rearm_event;
    logic                     is_frozen;
    logic [BYTE_BITS-1:0]     freeze_origin;
    logic [BYTE_BITS-1:0]     freeze_cause;
    logic [TIME_BITS-1:0]     freeze_instant;

    modport source (
        output valid, send_valid, send_id, send_byte0, send_byte1, send_byte2,
               freeze_event, rearm_event, is_frozen, freeze_origin,
               freeze_cause, freeze_instant,
        input  ready
    );

    modport sink (
        input  valid, send_valid, send_id, send_byte0, send_byte1, send_byte2,
               freeze_event, rearm_event, is_frozen, freeze_origin,
               freeze_cause, freeze_instant,
        output ready
    );
endinterface

// ===== hw/rtl/freeze_rearm_broadcast_tracker.sv =====
`timescale 1ns / 1ps
// Result: registered, shown on o_rsp in the cycle after the input transfer.
// Throughput: one item per cycle; the single result register is the only
//   stage, and a stalled result holds input ready low until it is taken.
// Reset: i_rst_n synchronous, active low; clears the tracker state to its
//   idle values (last origin/sequence 0xFF), config registers to defaults.

module freeze_rearm_broadcast_tracker
    import frbt_pkg::*;
#(
    parameter int TIME_BITS = 48
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // item channels
    frbt_in_if.sink                  i_req,
    frbt_out_if.source               o_rsp
);

    // Report only the low INSTANT_OUT_BITS of the timestamp; for narrower
    // TIME_BITS the shift clears every bit and the mask is all ones.
    localparam logic [TIME_BITS-1:0] INSTANT_MASK =
        ~({TIME_BITS{1'b1}} << INSTANT_OUT_BITS);

    // ---------------- configuration registers ----------------
    logic [BYTE_BITS-1:0]     r_self;
    logic [FRAME_ID_BITS-1:0] r_freeze_id;
    logic [FRAME_ID_BITS-1:0] r_rearm_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self      <= '0;
            r_freeze_id <= FREEZE_ID_RESET;
            r_rearm_id  <= REARM_ID_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SELF:      r_self      <= i_cfg_data[BYTE_BITS-1:0];
                CFG_FREEZE_ID: r_freeze_id <= i_cfg_data[FRAME_ID_BITS-1:0];
                CFG_REARM_ID:  r_rearm_id  <= i_cfg_data[FRAME_ID_BITS-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ---------------- tracker state ----------------
    logic                 r_frozen,    n_frozen;
    logic [BYTE_BITS-1:0] r_origin,    n_origin;
    logic [BYTE_BITS-1:0] r_cause,     n_cause;
    logic [BYTE_BITS-1:0] r_last_seq,  n_last_seq;
    logic [BYTE_BITS-1:0] r_last_orig, n_last_orig;
    logic [TIME_BITS-1:0] r_instant,   n_instant;

    // ---------------- result register ----------------
    logic                     r_out_valid;
    logic                     r_send_valid,  n_send_valid;
    logic [FRAME_ID_BITS-1:0] r_send_id,     n_send_id;
    logic [BYTE_BITS-1:0]     r_send_byte0,  n_send_byte0;
    logic [BYTE_BITS-1:0]     r_send_byte1,  n_send_byte1;
    logic [BYTE_BITS-1:0]     r_send_byte2,  n_send_byte2;
    logic                     r_freeze_evt,  n_freeze_evt;
    logic                     r_rearm_evt,   n_rearm_evt;

    logic                 accept;
    logic                 is_freeze_frame;
    logic                 is_rearm_frame;
    logic                 from_self;
    logic                 duplicate;
    logic [BYTE_BITS-1:0] next_seq;

    // The result register frees up in the same cycle it is taken downstream.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign is_freeze_frame = (i_req.frame_id == r_freeze_id)
                          && (i_req.frame_len >= MIN_FREEZE_LEN);
    assign is_rearm_frame  = (i_req.frame_id == r_rearm_id)
                          && (i_req.frame_len >= MIN_REARM_LEN);
    assign from_self       = (i_req.rx_byte0 == r_self);
    assign duplicate       = (i_req.rx_byte0 == r_last_orig)
                          && (i_req.rx_byte2 == r_last_seq);
    assign next_seq        = r_last_seq + BYTE_BITS'(1);

    always_comb begin
        n_frozen     = r_frozen;
        n_origin     = r_origin;
        n_cause      = r_cause;
        n_last_seq   = r_last_seq;
        n_last_orig  = r_last_orig;
        n_instant    = r_instant;
        n_send_valid = 1'b0;
        n_send_id    = '0;
        n_send_byte0 = '0;
        n_send_byte1 = '0;
        n_send_byte2 = '0;
        n_freeze_evt = 1'b0;
        n_rearm_evt  = 1'b0;

        unique case (t_cmd'(i_req.cmd))
            CMD_RX: begin
                // freeze id wins when both ids match; a short freeze frame
                // falls through to the re-arm test
                priority if (is_freeze_frame) begin
                    if (!from_self && !duplicate) begin
                        n_last_orig  = i_req.rx_byte0;
                        n_last_seq   = i_req.rx_byte2;
                        n_instant    = i_req.now_us;
                        n_origin     = i_req.rx_byte0;
                        n_cause      = i_req.rx_byte1;
                        n_frozen     = 1'b1;
                        n_freeze_evt = 1'b1;
                    end
                end else if (is_rearm_frame) begin
                    if (!from_self) begin
                        n_frozen    = 1'b0;
                        n_rearm_evt = 1'b1;
                    end
                end else begin
                    // unrelated frame
                end
            end
            CMD_TRIGGER: begin
                // local freeze: record it and broadcast, no local event
                n_instant    = i_req.now_us;
                n_origin     = r_self;
                n_cause      = i_req.trigger_cause;
                n_frozen     = 1'b1;
                n_last_seq   = next_seq;
                n_last_orig  = r_self;
                n_send_valid = 1'b1;
                n_send_id    = r_freeze_id;
                n_send_byte0 = r_self;
                n_send_byte1 = i_req.trigger_cause;
                n_send_byte2 = next_seq;
            end
            CMD_REARM: begin
                n_frozen     = 1'b0;
                n_last_seq   = next_seq;
                n_rearm_evt  = 1'b1;
                n_send_valid = 1'b1;
                n_send_id    = r_rearm_id;
                n_send_byte0 = r_self;
                n_send_byte1 = next_seq;
            end
            default: begin
                // unused command: nothing changes, nothing sent
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frozen    <= 1'b0;
            r_origin    <= '0;
            r_cause     <= '0;
            r_last_seq  <= LAST_RESET;
            r_last_orig <= LAST_RESET;
            r_instant   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_frozen    <= n_frozen;
                r_origin    <= n_origin;
                r_cause     <= n_cause;
                r_last_seq  <= n_last_seq;
                r_last_orig <= n_last_orig;
                r_instant   <= n_instant;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; the state snapshot comes from the updated values
    logic                 r_is_frozen;
    logic [BYTE_BITS-1:0] r_o_origin;
    logic [BYTE_BITS-1:0] r_o_cause;
    logic [TIME_BITS-1:0] r_o_instant;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_send_valid <= n_send_valid;
            r_send_id    <= n_send_id;
            r_send_byte0 <= n_send_byte0;
            r_send_byte1 <= n_send_byte1;
            r_send_byte2 <= n_send_byte2;
            r_freeze_evt <= n_freeze_evt;
            r_rearm_evt  <= n_rearm_evt;
            r_is_frozen  <= n_frozen;
            r_o_origin   <= n_origin;
            r_o_cause    <= n_cause;
            r_o_instant  <= n_instant & INSTANT_MASK;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.send_valid     = r_send_valid;
    assign o_rsp.send_id        = r_send_id;
    assign o_rsp.send_byte0     = r_send_byte0;
    assign o_rsp.send_byte1     = r_send_byte1;
    assign o_rsp.send_byte2     = r_send_byte2;
    assign o_rsp.freeze_event   = r_freeze_evt;
    assign o_rsp.rearm_event    = r_rearm_evt;
    assign o_rsp.is_frozen      = r_is_frozen;
    assign o_rsp.freeze_origin  = r_o_origin;
    assign o_rsp.freeze_cause   = r_o_cause;
    assign o_rsp.freeze_instant = r_o_instant;

endmodule

// ===== dv/tb_freeze_rearm_broadcast_tracker.sv =====
`timescale 1ns / 1ps

module tb_freeze_rearm_broadcast_tracker
    import frbt_pkg::*;
();

    localparam int TIME_BITS = 48;

    // cmd encoding 3 has no meaning; the block must treat it as a no-op
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam logic [FRAME_ID_BITS-1:0] ID_ALL_ONES = {FRAME_ID_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]     NOW_MAX     = {TIME_BITS{1'b1}};

    // one request transfer on i_req
    typedef struct packed {
        logic [CMD_BITS-1:0]      cmd;
        logic [FRAME_ID_BITS-1:0] frame_id;
        logic [LEN_BITS-1:0]      frame_len;
        logic [BYTE_BITS-1:0]     origin;      // rx byte 0
        logic [BYTE_BITS-1:0]     cause;       // rx byte 1
        logic [BYTE_BITS-1:0]     seq;         // rx byte 2
        logic [BYTE_BITS-1:0]     trig_cause;
        logic [TIME_BITS-1:0]     now_us;
    } t_bcast_req;

    // one response transfer on o_rsp
    typedef struct packed {
        logic                     send_valid;
        logic [FRAME_ID_BITS-1:0] send_id;
        logic [BYTE_BITS-1:0]     send_byte0;
        logic [BYTE_BITS-1:0]     send_byte1;
        logic [BYTE_BITS-1:0]     send_byte2;
        logic                     freeze_event;
        logic                     rearm_event;
        logic                     is_frozen;
        logic [BYTE_BITS-1:0]     freeze_origin;
        logic [BYTE_BITS-1:0]     freeze_cause;
        logic [TIME_BITS-1:0]     freeze_instant;
    } t_bcast_rsp;

    // ------------------------------------------------------------------
    // Scoreboard: keeps a private copy of the tracker state and registers,
    // turns each accepted request into the response it must produce, and
    // compares responses in order.
    // ------------------------------------------------------------------
    class tracker_sb;
        logic [BYTE_BITS-1:0]     self_id;
        logic [FRAME_ID_BITS-1:0] freeze_id;
        logic [FRAME_ID_BITS-1:0] rearm_id;

        logic                     frozen;
        logic [BYTE_BITS-1:0]     origin_q;
        logic [BYTE_BITS-1:0]     cause_q;
        logic [BYTE_BITS-1:0]     last_seq;
        logic [BYTE_BITS-1:0]     last_orig;
        logic [TIME_BITS-1:0]     instant_q;

        t_bcast_rsp  tracker_rsp_q[$];
        int unsigned mismatches;
        int unsigned rsp_count;

        function new();
            self_id     = '0;
            freeze_id   = FREEZE_ID_RESET;
            rearm_id    = REARM_ID_RESET;
            frozen      = 1'b0;
            origin_q    = '0;
            cause_q     = '0;
            last_seq    = LAST_RESET;
            last_orig   = LAST_RESET;
            instant_q   = '0;
            mismatches  = 0;
            rsp_count   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_SELF:      self_id   = data[BYTE_BITS-1:0];
                CFG_FREEZE_ID: freeze_id = data[FRAME_ID_BITS-1:0];
                CFG_REARM_ID:  rearm_id  = data[FRAME_ID_BITS-1:0];
                default: ;
            endcase
        endfunction

        // advance the tracker state by one request and queue its response
        function void note_request(t_bcast_req r);
            t_bcast_rsp           e;
            logic [BYTE_BITS-1:0] nxt_seq;
            e = '0;
            nxt_seq = last_seq + 8'd1;
            case (r.cmd)
                CMD_RX: begin
                    // freeze id wins when both ids match and the frame is long enough
                    if (r.frame_id == freeze_id && r.frame_len >= MIN_FREEZE_LEN) begin
                        if (r.origin != self_id &&
                            !(r.origin == last_orig && r.seq == last_seq)) begin
                            last_orig = r.origin;
                            last_seq  = r.seq;
                            instant_q = r.now_us;
                            origin_q  = r.origin;
                            cause_q   = r.cause;
                            frozen    = 1'b1;
                            e.freeze_event = 1'b1;
                        end
                    end else if (r.frame_id == rearm_id && r.frame_len >= MIN_REARM_LEN) begin
                        if (r.origin != self_id) begin
                            frozen = 1'b0;
                            e.rearm_event = 1'b1;
                        end
                    end
                end
                CMD_TRIGGER: begin
                    instant_q = r.now_us;
                    origin_q  = self_id;
                    cause_q   = r.trig_cause;
                    frozen    = 1'b1;
                    last_seq  = nxt_seq;
                    last_orig = self_id;
                    e.send_valid = 1'b1;
                    e.send_id    = freeze_id;
                    e.send_byte0 = self_id;
                    e.send_byte1 = r.trig_cause;
                    e.send_byte2 = nxt_seq;
                end
                CMD_REARM: begin
                    frozen   = 1'b0;
                    last_seq = nxt_seq;
                    e.rearm_event = 1'b1;
                    e.send_valid  = 1'b1;
                    e.send_id     = rearm_id;
                    e.send_byte0  = self_id;
                    e.send_byte1  = nxt_seq;
                end
                default: ;
            endcase
            e.is_frozen      = frozen;
            e.freeze_origin  = origin_q;
            e.freeze_cause   = cause_q;
            e.freeze_instant = instant_q;
            tracker_rsp_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("response %0d %s: got 0x%0h, want 0x%0h",
                                 rsp_count, name, got, want));
        endtask

        task check_response(t_bcast_rsp got);
            t_bcast_rsp want;
            if (tracker_rsp_q.size() == 0) begin
                report("response transfer with nothing outstanding");
                return;
            end
            want = tracker_rsp_q.pop_front();
            cmp("send_valid",     64'(got.send_valid),     64'(want.send_valid));
            cmp("send_id",        64'(got.send_id),        64'(want.send_id));
            cmp("send_byte0",     64'(got.send_byte0),     64'(want.send_byte0));
            cmp("send_byte1",     64'(got.send_byte1),     64'(want.send_byte1));
            cmp("send_byte2",     64'(got.send_byte2),     64'(want.send_byte2));
            cmp("freeze_event",   64'(got.freeze_event),   64'(want.freeze_event));
            cmp("rearm_event",    64'(got.rearm_event),    64'(want.rearm_event));
            cmp("is_frozen",      64'(got.is_frozen),      64'(want.is_frozen));
            cmp("freeze_origin",  64'(got.freeze_origin),  64'(want.freeze_origin));
            cmp("freeze_cause",   64'(got.freeze_cause),   64'(want.freeze_cause));
            cmp("freeze_instant", 64'(got.freeze_instant), 64'(want.freeze_instant));
            rsp_count++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    frbt_in_if  #(.TIME_BITS(TIME_BITS)) req_if ();
    frbt_out_if #(.TIME_BITS(TIME_BITS)) rsp_if ();

    freeze_rearm_broadcast_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    tracker_sb sb;

    // idle chance in percent per cycle, per side; changed between phases
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    // ------------------------------------------------------------------
    // Response side: sample at the edge (values from before the edge),
    // then pick the next ready at random.
    // ------------------------------------------------------------------
    initial begin
        t_bcast_rsp got;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got.send_valid     = rsp_if.send_valid;
                got.send_id        = rsp_if.send_id;
                got.send_byte0     = rsp_if.send_byte0;
                got.send_byte1     = rsp_if.send_byte1;
                got.send_byte2     = rsp_if.send_byte2;
                got.freeze_event   = rsp_if.freeze_event;
                got.rearm_event    = rsp_if.rearm_event;
                got.is_frozen      = rsp_if.is_frozen;
                got.freeze_origin  = rsp_if.freeze_origin;
                got.freeze_cause   = rsp_if.freeze_cause;
                got.freeze_instant = rsp_if.freeze_instant;
                sb.check_response(got);
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------
    function automatic t_bcast_req mk_req(logic [CMD_BITS-1:0] cmd,
                                          logic [FRAME_ID_BITS-1:0] id,
                                          logic [LEN_BITS-1:0] len,
                                          logic [BYTE_BITS-1:0] b0, b1, b2, tcause,
                                          logic [TIME_BITS-1:0] now);
        t_bcast_req r;
        r.cmd        = cmd;
        r.frame_id   = id;
        r.frame_len  = len;
        r.origin     = b0;
        r.cause      = b1;
        r.seq        = b2;
        r.trig_cause = tcause;
        r.now_us     = now;
        return r;
    endfunction

    // Drive one request and hold it until the transfer happens. Valid is
    // left high afterwards so back-to-back transfers need no extra step.
    task automatic send_req(input t_bcast_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= r.cmd;
        req_if.frame_id      <= r.frame_id;
        req_if.frame_len     <= r.frame_len;
        req_if.rx_byte0      <= r.origin;
        req_if.rx_byte1      <= r.cause;
        req_if.rx_byte2      <= r.seq;
        req_if.trigger_cause <= r.trig_cause;
        req_if.now_us        <= r.now_us;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Stop sending and wait for every outstanding response. Each request
    // gives exactly one response, so an empty queue means the DUT is idle.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (sb.tracker_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; caller drops it
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(input logic [CFG_DATA_BITS-1:0] self_word,
                                input logic [FRAME_ID_BITS-1:0] fid,
                                input logic [FRAME_ID_BITS-1:0] rid);
        write_reg(CFG_SELF, self_word);
        write_reg(CFG_FREEZE_ID, fid);
        write_reg(CFG_REARM_ID, rid);
        i_cfg_we <= 1'b0;
    endtask

    // Random request, biased toward frames the tracker actually reacts to:
    // configured ids, own echoes and repeats of the last origin/sequence.
    function automatic t_bcast_req rand_req();
        t_bcast_req  r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)      r.cmd = CMD_RX;
        else if (pick < 70) r.cmd = CMD_TRIGGER;
        else if (pick < 93) r.cmd = CMD_REARM;
        else                r.cmd = CMD_UNUSED;

        pick = $urandom_range(99);
        if (pick < 45)      r.frame_id = sb.freeze_id;
        else if (pick < 80) r.frame_id = sb.rearm_id;
        else if (pick < 88) r.frame_id = sb.freeze_id ^ (29'd1 << $urandom_range(28));
        else                r.frame_id = FRAME_ID_BITS'($urandom);

        // mostly legal lengths, now and then the oversized ones
        if ($urandom_range(9) == 0) r.frame_len = LEN_BITS'($urandom_range(15));
        else                        r.frame_len = LEN_BITS'($urandom_range(8));

        pick = $urandom_range(99);
        if (pick < 15)      r.origin = sb.self_id;
        else if (pick < 35) r.origin = sb.last_orig;
        else if (pick < 65) r.origin = BYTE_BITS'($urandom_range(3));
        else                r.origin = BYTE_BITS'($urandom);

        if ($urandom_range(99) < 35) r.seq = sb.last_seq;
        else                         r.seq = BYTE_BITS'($urandom);

        r.cause      = BYTE_BITS'($urandom);
        r.trig_cause = BYTE_BITS'($urandom);
        r.now_us     = TIME_BITS'({$urandom, $urandom});
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [FRAME_ID_BITS-1:0] fid;
        logic [FRAME_ID_BITS-1:0] rid;
        logic [FRAME_ID_BITS-1:0] same_id;
        logic [CFG_DATA_BITS-1:0] self_word;
        int unsigned              pick;

        sb = new();
        src_idle_pct = 17;
        snk_idle_pct = 55;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_SELF;
        i_cfg_data           <= '0;
        req_if.valid         <= 1'b0;
        req_if.cmd           <= CMD_RX;
        req_if.frame_id      <= '0;
        req_if.frame_len     <= '0;
        req_if.rx_byte0      <= '0;
        req_if.rx_byte1      <= '0;
        req_if.rx_byte2      <= '0;
        req_if.trigger_cause <= '0;
        req_if.now_us        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset register values (self 0, ids 0 / 1) ---
        // own echo from node 0
        send_req(mk_req(CMD_RX, FREEZE_ID_RESET, 4'd3, 8'h00, 8'h11, 8'h05, 8'h00, '0));
        // origin/sequence equal to the post-reset last values: a duplicate
        send_req(mk_req(CMD_RX, FREEZE_ID_RESET, 4'd3, 8'hFF, 8'h11, 8'hFF, 8'h00, '0));
        // accepted remote freeze, timestamp at its maximum
        send_req(mk_req(CMD_RX, FREEZE_ID_RESET, 4'd3, 8'h03, 8'h22, 8'h00, 8'h00, NOW_MAX));
        send_req(mk_req(CMD_RX, REARM_ID_RESET, 4'd1, 8'h04, 8'h00, 8'h00, 8'h00, '0));
        send_req(mk_req(CMD_TRIGGER, '0, '0, 8'h00, 8'h00, 8'h00, 8'h00, '0));
        send_req(mk_req(CMD_REARM, '0, '0, 8'h00, 8'h00, 8'h00, 8'h00, NOW_MAX));
        drain_responses();

        // --- directed: extreme ids, distinct ---
        write_config(29'h0AAA_AAA5, ID_ALL_ONES, '0);
        // short freeze frame with ids apart: neither freeze nor re-arm
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd2, 8'h5A, 8'h01, 8'h80, 8'h00, '0));
        // length above 8 counts as long enough
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd15, 8'h5A, 8'hFF, 8'h80, 8'hFF, 48'h1));
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd8, 8'h5A, 8'h01, 8'h80, 8'h00, 48'h2));
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd8, 8'h5A, 8'h01, 8'h81, 8'h00, 48'h3));
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd3, 8'hA5, 8'h02, 8'h90, 8'h00, 48'h4));
        // zero-length re-arm, own re-arm echo, then a real one
        send_req(mk_req(CMD_RX, '0, 4'd0, 8'h01, 8'h00, 8'h00, 8'h00, '0));
        send_req(mk_req(CMD_RX, '0, 4'd1, 8'hA5, 8'h00, 8'h00, 8'h00, '0));
        send_req(mk_req(CMD_RX, '0, 4'd4, 8'h00, 8'hFF, 8'hFF, 8'h00, '0));
        send_req(mk_req(CMD_RX, 29'h1234567, 4'd8, 8'h77, 8'h77, 8'h77, 8'h00, NOW_MAX));
        // reserved command with every field at its top value
        send_req(mk_req(CMD_UNUSED, ID_ALL_ONES, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, NOW_MAX));
        // sequence 0xFF from a remote node, then local ones wrap it to 0 and 1
        send_req(mk_req(CMD_RX, ID_ALL_ONES, 4'd3, 8'h33, 8'h44, 8'hFF, 8'h00, 48'h5));
        send_req(mk_req(CMD_TRIGGER, '0, '0, 8'h00, 8'h00, 8'h00, 8'hFF, 48'h6));
        send_req(mk_req(CMD_REARM, '0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 48'h7));
        drain_responses();

        // --- directed: both ids equal, freeze test has priority ---
        same_id = 29'h0ABC_DEF;
        write_config(29'h1FFF_FF00, same_id, same_id);
        send_req(mk_req(CMD_RX, same_id, 4'd3, 8'h10, 8'h20, 8'h30, 8'h00, 48'h8));
        // too short for a freeze, so it is taken as a re-arm
        send_req(mk_req(CMD_RX, same_id, 4'd2, 8'h10, 8'h20, 8'h31, 8'h00, 48'h9));
        send_req(mk_req(CMD_RX, same_id, 4'd0, 8'h10, 8'h20, 8'h32, 8'h00, 48'hA));
        send_req(mk_req(CMD_RX, same_id, 4'd9, 8'hFF, 8'h20, 8'h33, 8'h00, 48'hB));
        send_req(mk_req(CMD_TRIGGER, same_id, '0, 8'h00, 8'h00, 8'h00, 8'h5C, 48'hC));
        drain_responses();

        // --- random: three idle profiles, three register settings each ---
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 17; snk_idle_pct = 55; end
                1: begin src_idle_pct = 55; snk_idle_pct = 17; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                // sender holds off until the pipe is empty, then reprograms
                drain_responses();
                pick = $urandom_range(3);
                self_word = CFG_DATA_BITS'($urandom);  // upper bits must be ignored
                if (pick == 0)      self_word[BYTE_BITS-1:0] = 8'h00;
                else if (pick == 1) self_word[BYTE_BITS-1:0] = 8'hFF;
                fid = FRAME_ID_BITS'($urandom);
                rid = FRAME_ID_BITS'($urandom);
                case ($urandom_range(3))
                    0: rid = fid;
                    1: fid = ID_ALL_ONES;
                    2: rid = '0;
                    default: ;
                endcase
                write_config(self_word, fid, rid);
                for (int k = 0; k < 208; k++)
                    send_req(rand_req());
            end
        end

        drain_responses();
        // wait on after the drain so any stray response is caught
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.tracker_rsp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #400_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
